>>> src/psis_pkg.sv
package psis_pkg;

  // Width of every deadline counter and of the debounce counter.
  localparam int TimerBits = 16;
  // Width of one configuration register.
  localparam int CfgBits = 16;
  // Width of the configuration register index on the write port.
  localparam int CfgIndexBits = 4;
  // Number of configuration registers.
  localparam int CfgCount = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexBits-1:0] REG_DEBOUNCE   = 4'd0;
  localparam logic [CfgIndexBits-1:0] REG_ACC_DELAY  = 4'd1;
  localparam logic [CfgIndexBits-1:0] REG_IG_DELAY   = 4'd2;
  localparam logic [CfgIndexBits-1:0] REG_STARTER    = 4'd3;
  localparam logic [CfgIndexBits-1:0] REG_COUNTDOWN  = 4'd4;
  localparam logic [CfgIndexBits-1:0] REG_SLOW_BLINK = 4'd5;
  localparam logic [CfgIndexBits-1:0] REG_FAST_ON    = 4'd6;
  localparam logic [CfgIndexBits-1:0] REG_FAST_OFF   = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [CfgBits-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CfgBits-1:0] ACC_DELAY_RST  = 16'd1000;
  localparam logic [CfgBits-1:0] IG_DELAY_RST   = 16'd2000;
  localparam logic [CfgBits-1:0] STARTER_RST    = 16'd1000;
  localparam logic [CfgBits-1:0] COUNTDOWN_RST  = 16'd5000;
  localparam logic [CfgBits-1:0] SLOW_BLINK_RST = 16'd500;
  localparam logic [CfgBits-1:0] FAST_ON_RST    = 16'd200;
  localparam logic [CfgBits-1:0] FAST_OFF_RST   = 16'd50;

  // Input command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ENGINE = 1'b1;

  // Button levels (active-low pin with pull-up).
  localparam logic BTN_PRESSED  = 1'b0;
  localparam logic BTN_RELEASED = 1'b1;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ACC       = 3'd1,
    PH_IGN       = 3'd2,
    PH_STARTER   = 3'd3,
    PH_COUNTDOWN = 3'd4
  } phase_t;

  typedef struct packed {
    logic command;
    logic button_level;
    logic engine_value;
  } in_item_t;

  typedef struct packed {
    logic       acc_relay;
    logic       ign_relay;
    logic       starter_relay;
    logic       led_level;
    logic       engine_on;
    logic       reset_request;
    logic       engine_report_valid;
    logic       engine_report_value;
    logic [2:0] phase;
  } out_item_t;

  // Saturating decrement of a deadline counter.
  function automatic logic [TimerBits-1:0] dec_sat(input logic [TimerBits-1:0] t);
    dec_sat = (t == '0) ? '0 : t - 1'b1;
  endfunction

  // Load of a configuration value into a deadline counter.
  function automatic logic [TimerBits-1:0] load_timer(input logic [CfgBits-1:0] v);
    load_timer = TimerBits'(v);
  endfunction

endpackage

>>> src/push_start_ignition_sequencer.sv
// Push-start ignition sequencer. Each item is either a one-millisecond tick
// carrying the raw level of an active-low start button, or a write of the
// engine-on flag. Every item gives exactly one result item with the relay,
// LED and engine levels after it, plus the one-item reset request and
// engine report flags. The whole update of the timers, debounce counter and
// phase is one register-to-register pass, so an item may be offered on every
// clock while in_stall is low; its result goes to the output register, or to
// the skid register while a result waits there. A two-entry output stage
// (output register and skid register) lets the block take items while a
// result waits, and in_stall rises only when both entries are full.
// Configuration writes are always ready; indexes beyond the last register are ignored.
module push_start_ignition_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psis_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psis_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psis_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [psis_pkg::CfgBits-1:0]        cfg_data
);

  localparam logic [psis_pkg::TimerBits-1:0] CountMax = '1;

  // Configuration registers.
  logic [psis_pkg::CfgBits-1:0] cfg [psis_pkg::CfgCount];

  // Sequencer state.
  psis_pkg::phase_t                 phase_reg, phase_next;
  logic [psis_pkg::TimerBits-1:0]   step_timer, step_timer_next;
  logic [psis_pkg::TimerBits-1:0]   window_timer, window_timer_next;
  logic [psis_pkg::TimerBits-1:0]   stable_count, stable_count_next;
  logic [psis_pkg::TimerBits-1:0]   led_timer, led_timer_next;
  logic last_raw, last_raw_next;
  logic stable_level, stable_level_next;
  logic engine_flag, engine_flag_next;
  logic acc_reg, acc_reg_next;
  logic ign_reg, ign_reg_next;
  logic starter_reg, starter_reg_next;
  logic led_reg, led_reg_next;
  logic fast_mode, fast_mode_next;
  logic rst_req, rep_valid, rep_value;

  // Output stage.
  psis_pkg::out_item_t result, skid_item;
  logic skid_valid;
  logic accept, take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[psis_pkg::REG_DEBOUNCE[2:0]]   <= psis_pkg::DEBOUNCE_RST;
      cfg[psis_pkg::REG_ACC_DELAY[2:0]]  <= psis_pkg::ACC_DELAY_RST;
      cfg[psis_pkg::REG_IG_DELAY[2:0]]   <= psis_pkg::IG_DELAY_RST;
      cfg[psis_pkg::REG_STARTER[2:0]]    <= psis_pkg::STARTER_RST;
      cfg[psis_pkg::REG_COUNTDOWN[2:0]]  <= psis_pkg::COUNTDOWN_RST;
      cfg[psis_pkg::REG_SLOW_BLINK[2:0]] <= psis_pkg::SLOW_BLINK_RST;
      cfg[psis_pkg::REG_FAST_ON[2:0]]    <= psis_pkg::FAST_ON_RST;
      cfg[psis_pkg::REG_FAST_OFF[2:0]]   <= psis_pkg::FAST_OFF_RST;
    end else if (cfg_valid && cfg_ready && cfg_index <= psis_pkg::REG_FAST_OFF) begin
      cfg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Next state for one item: timers, LED, debounce, then the phase handler.
  always_comb begin
    phase_next        = phase_reg;
    step_timer_next   = step_timer;
    window_timer_next = window_timer;
    stable_count_next = stable_count;
    led_timer_next    = led_timer;
    last_raw_next     = last_raw;
    stable_level_next = stable_level;
    engine_flag_next  = engine_flag;
    acc_reg_next      = acc_reg;
    ign_reg_next      = ign_reg;
    starter_reg_next  = starter_reg;
    led_reg_next      = led_reg;
    fast_mode_next    = fast_mode;
    rst_req           = 1'b0;
    rep_valid         = 1'b0;
    rep_value         = 1'b0;

    if (in_item.command == psis_pkg::CMD_ENGINE) begin
      engine_flag_next = in_item.engine_value;
    end else begin
      step_timer_next   = psis_pkg::dec_sat(step_timer);
      window_timer_next = psis_pkg::dec_sat(window_timer);
      led_timer_next    = psis_pkg::dec_sat(led_timer);

      // LED toggles and reloads with the period for its new level.
      if (led_timer_next == '0) begin
        led_reg_next = !led_reg;
        if (fast_mode) begin
          led_timer_next = psis_pkg::load_timer(led_reg_next ?
                             cfg[psis_pkg::REG_FAST_ON[2:0]] :
                             cfg[psis_pkg::REG_FAST_OFF[2:0]]);
        end else begin
          led_timer_next = psis_pkg::load_timer(cfg[psis_pkg::REG_SLOW_BLINK[2:0]]);
        end
      end

      // Debounce: count ticks since the raw level last changed.
      if (in_item.button_level != last_raw) begin
        last_raw_next     = in_item.button_level;
        stable_count_next = '0;
      end else if (stable_count != CountMax) begin
        stable_count_next = stable_count + 1'b1;
      end

      if ((stable_count_next > psis_pkg::TimerBits'(cfg[psis_pkg::REG_DEBOUNCE[2:0]])) &&
          (in_item.button_level != stable_level)) begin
        if (stable_level == psis_pkg::BTN_RELEASED &&
            in_item.button_level == psis_pkg::BTN_PRESSED) begin
          if (engine_flag) begin
            rst_req = 1'b1;
          end else if (phase_reg == psis_pkg::PH_IDLE) begin
            acc_reg_next      = 1'b1;
            rep_valid         = 1'b1;
            phase_next        = psis_pkg::PH_ACC;
            step_timer_next   = psis_pkg::load_timer(cfg[psis_pkg::REG_ACC_DELAY[2:0]]);
            window_timer_next = psis_pkg::load_timer(cfg[psis_pkg::REG_COUNTDOWN[2:0]]);
            fast_mode_next    = 1'b0;
          end else if (phase_reg == psis_pkg::PH_COUNTDOWN) begin
            starter_reg_next  = 1'b1;
            phase_next        = psis_pkg::PH_STARTER;
            step_timer_next   = psis_pkg::load_timer(cfg[psis_pkg::REG_STARTER[2:0]]);
            window_timer_next = psis_pkg::load_timer(cfg[psis_pkg::REG_COUNTDOWN[2:0]]);
            fast_mode_next    = 1'b1;
          end
        end
        stable_level_next = in_item.button_level;
      end

      // Phase handler works on the phase left by a press in this tick.
      case (phase_next)
        psis_pkg::PH_ACC: begin
          if (step_timer_next == '0) begin
            ign_reg_next    = 1'b1;
            phase_next      = psis_pkg::PH_IGN;
            step_timer_next = psis_pkg::load_timer(cfg[psis_pkg::REG_IG_DELAY[2:0]]);
          end
        end
        psis_pkg::PH_IGN: begin
          if (step_timer_next == '0) begin
            starter_reg_next = 1'b1;
            phase_next       = psis_pkg::PH_STARTER;
            step_timer_next  = psis_pkg::load_timer(cfg[psis_pkg::REG_STARTER[2:0]]);
            fast_mode_next   = 1'b1;
          end
        end
        psis_pkg::PH_STARTER: begin
          if (step_timer_next == '0) begin
            starter_reg_next = 1'b0;
            phase_next       = psis_pkg::PH_COUNTDOWN;
            fast_mode_next   = 1'b1;
          end
        end
        psis_pkg::PH_COUNTDOWN: begin
          if (window_timer_next == '0) begin
            rep_valid        = 1'b1;
            rep_value        = 1'b1;
            engine_flag_next = 1'b1;
            phase_next       = psis_pkg::PH_IDLE;
            fast_mode_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result item for the accepted input item.
  always_comb begin
    result.acc_relay           = acc_reg_next;
    result.ign_relay           = ign_reg_next;
    result.starter_relay       = starter_reg_next;
    result.led_level           = led_reg_next;
    result.engine_on           = engine_flag_next;
    result.reset_request       = rst_req;
    result.engine_report_valid = rep_valid;
    result.engine_report_value = rep_value;
    result.phase               = phase_next;
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= psis_pkg::PH_IDLE;
      step_timer   <= '0;
      window_timer <= '0;
      stable_count <= '0;
      led_timer    <= psis_pkg::load_timer(psis_pkg::SLOW_BLINK_RST);
      last_raw     <= psis_pkg::BTN_RELEASED;
      stable_level <= psis_pkg::BTN_RELEASED;
      engine_flag  <= 1'b0;
      acc_reg      <= 1'b0;
      ign_reg      <= 1'b0;
      starter_reg  <= 1'b0;
      led_reg      <= 1'b0;
      fast_mode    <= 1'b0;
    end else if (accept) begin
      phase_reg    <= phase_next;
      step_timer   <= step_timer_next;
      window_timer <= window_timer_next;
      stable_count <= stable_count_next;
      led_timer    <= led_timer_next;
      last_raw     <= last_raw_next;
      stable_level <= stable_level_next;
      engine_flag  <= engine_flag_next;
      acc_reg      <= acc_reg_next;
      ign_reg      <= ign_reg_next;
      starter_reg  <= starter_reg_next;
      led_reg      <= led_reg_next;
      fast_mode    <= fast_mode_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept) begin
        out_item <= result;
      end
    end else if (accept) begin
      skid_item <= result;
    end
  end

endmodule

>>> src/psis_checker.sv
module psis_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input psis_pkg::out_item_t               out_item
);

  // A stalled result item stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The starter relay is driven exactly in the starter phase.
  a_starter_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.starter_relay ==
                   (out_item.phase == psis_pkg::PH_STARTER)))
    else $error("starter relay and phase disagree");

  // A reset request is only raised with the engine marked on.
  a_reset_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.reset_request |-> out_item.engine_on)
    else $error("reset request with engine off");

  // An engine-on report ends the sequence with the engine marked on.
  a_report_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.engine_report_value |->
      out_item.engine_report_valid && out_item.engine_on &&
      out_item.phase == psis_pkg::PH_IDLE)
    else $error("engine report inconsistent with state");

endmodule

bind push_start_ignition_sequencer psis_checker u_psis_checker (.*);
